FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int CAPACITY  = 256;
    localparam int REF_WIDTH = 32;

    // Fixed word field widths.
    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 9;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [REF_WIDTH-1:0] ref_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_NULL  = 2'd3
    } status_t;

    // Per-word decode handed from control to storage and result stage.
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        addr_t   addr;
        ref_t    wdata;
        status_t status;
        cnt_t    count;
    } deq_ctl_t;

    // Ring slot at base plus offset, wrapping once past the end.
    function automatic addr_t slot_after(addr_t base, cnt_t offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
        if (sum >= (CNT_W + 1)'(CAPACITY))
        begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/deq_if.sv
`default_nettype none

interface deq_req_if;
    logic                        valid;
    logic                        ready;
    logic [deq_pkg::OP_W-1:0]    op;
    logic [deq_pkg::VAL_W-1:0]   push_value;
    logic [deq_pkg::POS_W-1:0]   position;

    modport source (output valid, output op, output push_value, output position,
                    input ready);
    modport sink   (input valid, input op, input push_value, input position,
                    output ready);
endinterface

interface deq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::VAL_W-1:0]     read_value;
    logic [deq_pkg::STATUS_W-1:0]  status;
    logic [deq_pkg::OUT_CNT_W-1:0] count;

    modport source (output valid, output read_value, output status, output count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/deq_ctrl.sv
`default_nettype none

module deq_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [deq_pkg::OP_W-1:0]    op,
    input  wire logic [deq_pkg::VAL_W-1:0]   push_value,
    input  wire logic [deq_pkg::POS_W-1:0]   position,
    output deq_pkg::deq_ctl_t                ctl
);

    deq_pkg::addr_t head_reg;
    deq_pkg::addr_t head_next;
    deq_pkg::cnt_t  count_reg;
    deq_pkg::ref_t  val;
    deq_pkg::addr_t head_dec;
    logic           is_null;
    logic           is_full;
    logic           is_empty;

    always_comb
    begin
        val      = deq_pkg::REF_WIDTH'(push_value);
        is_null  = (val == '0);
        is_full  = (count_reg == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
        is_empty = (count_reg == '0);
        head_dec = (head_reg == '0) ? deq_pkg::ADDR_W'(deq_pkg::CAPACITY - 1)
                                    : head_reg - 1'b1;

        ctl.wr_en  = 1'b0;
        ctl.rd_en  = 1'b0;
        ctl.addr   = head_reg;
        ctl.wdata  = val;
        ctl.status = deq_pkg::ST_OK;
        ctl.count  = count_reg;
        head_next  = head_reg;

        case (op)
            deq_pkg::OP_PUSH_BACK:
            begin
                if (is_null)
                begin
                    ctl.status = deq_pkg::ST_NULL;
                end
                else if (is_full)
                begin
                    ctl.status = deq_pkg::ST_FULL;
                end
                else
                begin
                    ctl.wr_en = 1'b1;
                    ctl.addr  = deq_pkg::slot_after(head_reg, count_reg);
                    ctl.count = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_null)
                begin
                    ctl.status = deq_pkg::ST_NULL;
                end
                else if (is_full)
                begin
                    ctl.status = deq_pkg::ST_FULL;
                end
                else
                begin
                    ctl.wr_en = 1'b1;
                    ctl.addr  = head_dec;
                    ctl.count = count_reg + 1'b1;
                    head_next = head_dec;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    ctl.status = deq_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    ctl.addr  = deq_pkg::slot_after(head_reg, count_reg - 1'b1);
                    ctl.count = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    ctl.status = deq_pkg::ST_RANGE;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    ctl.addr  = head_reg;
                    ctl.count = count_reg - 1'b1;
                    head_next = deq_pkg::slot_after(head_reg, deq_pkg::CNT_W'(1));
                end
            end
            deq_pkg::OP_READ:
            begin
                if (deq_pkg::CMP_W'(position) >= deq_pkg::CMP_W'(count_reg))
                begin
                    ctl.status = deq_pkg::ST_RANGE;
                end
                else
                begin
                    // position is below count here, so it fits the count width
                    ctl.rd_en = 1'b1;
                    ctl.addr  = deq_pkg::slot_after(head_reg, deq_pkg::CNT_W'(position));
                end
            end
            default:
            begin
                ctl.status = deq_pkg::ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= ctl.count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/deq_mem.sv
`default_nettype none

module deq_mem (
    input  wire logic         clk,
    input  wire logic         accept,
    input  deq_pkg::deq_ctl_t ctl,
    output deq_pkg::ref_t     rd_data
);

    deq_pkg::ref_t mem_reg [deq_pkg::CAPACITY];
    deq_pkg::ref_t rd_data_reg;

    // One access per word: a word either writes or reads, never both.
    always_ff @(posedge clk)
    begin
        if (accept && ctl.wr_en)
        begin
            mem_reg[ctl.addr] <= ctl.wdata;
        end
        if (accept && ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[ctl.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/deq_out.sv
`default_nettype none

module deq_out (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  deq_pkg::deq_ctl_t ctl,
    input  deq_pkg::ref_t     rd_data,
    output logic              in_ready,
    deq_rsp_if.source         rsp
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_rd_reg;
    logic [deq_pkg::STATUS_W-1:0]  s1_status_reg;
    logic [deq_pkg::OUT_CNT_W-1:0] s1_count_reg;
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    logic [deq_pkg::VAL_W-1:0]     s2_value_reg;
    logic [deq_pkg::STATUS_W-1:0]  s2_status_reg;
    logic [deq_pkg::OUT_CNT_W-1:0] s2_count_reg;
    logic                          advance;

    always_comb
    begin
        advance       = s1_valid_reg && (!s2_valid_reg || rsp.ready);
        in_ready      = !s1_valid_reg || advance;
        s1_valid_next = accept || (s1_valid_reg && !advance);
        s2_valid_next = advance || (s2_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Hold the decode beside the memory read data until the word moves on.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg     <= ctl.rd_en;
            s1_status_reg <= ctl.status;
            s1_count_reg  <= deq_pkg::OUT_CNT_W'(ctl.count);
        end
        if (advance)
        begin
            s2_value_reg  <= s1_rd_reg ? deq_pkg::VAL_W'(rd_data) : '0;
            s2_status_reg <= s1_status_reg;
            s2_count_reg  <= s1_count_reg;
        end
    end

    assign rsp.valid      = s2_valid_reg;
    assign rsp.read_value = s2_value_reg;
    assign rsp.status     = s2_status_reg;
    assign rsp.count      = s2_count_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bounded_deque_with_index_top.sv
// Double-ended queue of up to 256 nonzero 32-bit references, kept as a ring
// buffer with a head pointer and a fill count. Each request word is one
// operation (push back, push front, pop back, pop front, read at index) and
// yields exactly one response word carrying the popped or read reference, a
// status code and the element count after the operation. The block takes one
// request every cycle while ready is high; the single-port element memory
// serves each operation in one access, and a response passes the first
// result stage and then the output register. A stalled response side still
// lets one more request in before ready drops. Element storage needs no
// clearing after reset: only live slots are ever read.
`default_nettype none

module bounded_deque_with_index_top (
    input  wire logic clk,
    input  wire logic rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    deq_pkg::deq_ctl_t ctl;
    deq_pkg::ref_t     rd_data;
    logic              in_ready;
    logic              accept;

    // Take a request word whenever the first result stage is free or moving.
    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;

    // Decode the operation against head and count; advance both on accept.
    deq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (req.op),
        .push_value (req.push_value),
        .position   (req.position),
        .ctl        (ctl)
    );

    // Write or read the element ring; read data lands in a register.
    deq_mem u_mem (
        .clk     (clk),
        .accept  (accept),
        .ctl     (ctl),
        .rd_data (rd_data)
    );

    // Pair read data with status and count, then hold in the output register.
    deq_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ctl      (ctl),
        .rd_data  (rd_data),
        .in_ready (in_ready),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/core/deq_checker.sv
`default_nettype none

`include "assert_macros.svh"

module deq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [deq_pkg::VAL_W-1:0]     rsp_read_value,
    input wire logic [deq_pkg::STATUS_W-1:0]  rsp_status,
    input wire logic [deq_pkg::OUT_CNT_W-1:0] rsp_count
);

    // A refused push into a full store only happens at capacity.
    `ASSERT_IMPLY(a_full_at_cap, clk, rst_n, rsp_valid && (rsp_status == deq_pkg::ST_FULL), rsp_count == deq_pkg::OUT_CNT_W'(deq_pkg::CAPACITY))

    // Every error word carries a zero reference.
    `ASSERT_IMPLY(a_err_zero, clk, rst_n, rsp_valid && (rsp_status != deq_pkg::ST_OK), rsp_read_value == '0)

    // Count never runs past capacity.
    `ASSERT_IMPLY(a_cnt_bound, clk, rst_n, rsp_valid, rsp_count <= deq_pkg::OUT_CNT_W'(deq_pkg::CAPACITY))

    // Hold a stalled response word.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_status) && $stable(rsp_count))

endmodule

bind bounded_deque_with_index_top deq_checker u_deq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status),
    .rsp_count      (rsp.count)
);

`default_nettype wire

FILE: tb/tb_bounded_deque_with_index_top.sv
`default_nettype none

module tb_bounded_deque_with_index_top;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // Run length and pacing knobs.
    localparam int RANDOM_WORDS   = 1930;
    localparam int IDLE_PCT       = 20;
    localparam int STALL_LIMIT    = 3000;   // cycles without any handshake
    localparam int DRAIN_CYCLES   = 20;     // response trails request through the result stages
    localparam int CALM_TX_FIRST  = 900;    // sender offers back to back in this span
    localparam int CALM_TX_LAST   = 1200;
    localparam int CALM_RX_FIRST  = 600;    // receiver never stalls in this span
    localparam int CALM_RX_LAST   = 1000;
    localparam int HOLD_RX_FIRST  = 1500;   // receiver refuses everything in this span
    localparam int HOLD_RX_LAST   = 1900;

    // One response word as the block should produce it.
    typedef struct packed {
        logic [VAL_W-1:0]     value;
        status_t              status;
        logic [OUT_CNT_W-1:0] count;
    } deq_result_t;

    // Shadow copy of the ring; predicts the response for every taken request.
    class deque_mirror;
        logic [REF_WIDTH-1:0] slots [CAPACITY];
        int unsigned          held;
        int unsigned          front;
        deq_result_t          pending_results [$];
        int unsigned          failures;

        function new();
            held      = 0;
            front     = 0;
            failures  = 0;
        endfunction

        function int unsigned ring_slot(int unsigned offset);
            return (front + offset) % CAPACITY;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] push_value,
                                   logic [POS_W-1:0] position);
            deq_result_t          res;
            logic [REF_WIDTH-1:0] ref_value;
            ref_value  = push_value[REF_WIDTH-1:0];
            res.value  = '0;
            res.status = ST_OK;
            case (op)
                OP_PUSH_BACK, OP_PUSH_FRONT:
                begin
                    // Null is checked ahead of full.
                    if (ref_value == '0)
                    begin
                        res.status = ST_NULL;
                    end
                    else if (held >= CAPACITY)
                    begin
                        res.status = ST_FULL;
                    end
                    else if (op == OP_PUSH_BACK)
                    begin
                        slots[ring_slot(held)] = ref_value;
                        held++;
                    end
                    else
                    begin
                        front = (front == 0) ? CAPACITY - 1 : front - 1;
                        slots[front] = ref_value;
                        held++;
                    end
                end
                OP_POP_BACK, OP_POP_FRONT:
                begin
                    if (held == 0)
                    begin
                        res.status = ST_RANGE;
                    end
                    else if (op == OP_POP_BACK)
                    begin
                        res.value = VAL_W'(slots[ring_slot(held - 1)]);
                        held--;
                    end
                    else
                    begin
                        res.value = VAL_W'(slots[front]);
                        front = ring_slot(1);
                        held--;
                    end
                end
                OP_READ:
                begin
                    if (int'(position) >= held)
                    begin
                        res.status = ST_RANGE;
                    end
                    else
                    begin
                        res.value = VAL_W'(slots[ring_slot(position)]);
                    end
                end
                default:
                begin
                    res.status = ST_RANGE;
                end
            endcase
            res.count = OUT_CNT_W'(held);
            pending_results.push_back(res);
        endfunction

        function void check_response(logic [VAL_W-1:0] value, logic [STATUS_W-1:0] status,
                                     logic [OUT_CNT_W-1:0] count);
            deq_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with nothing outstanding: value %h status %0d count %0d",
                         $time, value, status, count);
                failures++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (value !== exp_res.value)
            begin
                $display("%0t: read_value mismatch: expected %h actual %h",
                         $time, exp_res.value, value);
                failures++;
            end
            if (status !== exp_res.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_res.status, status);
                failures++;
            end
            if (count !== exp_res.count)
            begin
                $display("%0t: count mismatch: expected %0d actual %0d",
                         $time, exp_res.count, count);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    deq_req_if req_if ();
    deq_rsp_if rsp_if ();

    bounded_deque_with_index_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    deque_mirror mirror = new();

    int unsigned words_sent;  // request index, drives the calm span of the sender
    int unsigned quiet_cycles;

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request word from the falling edge and hold it until taken.
    // Idle cycles go in front of the word unless the sender is in its calm span.
    task automatic send_word(logic [OP_W-1:0] op, logic [VAL_W-1:0] push_value,
                             logic [POS_W-1:0] position);
        bit calm;
        calm = (words_sent >= CALM_TX_FIRST) && (words_sent < CALM_TX_LAST);
        @(negedge clk);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid      = 1'b1;
        req_if.op         = op;
        req_if.push_value = push_value;
        req_if.position   = position;
        // Sample ready at the rising edge; flops settle only after this.
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        mirror.note_request(op, push_value, position);
        words_sent++;
    endtask

    // Mostly random references, with null and all-ones mixed in.
    function automatic logic [VAL_W-1:0] pick_reference();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            return '0;
        end
        if (roll < 10)
        begin
            return '1;
        end
        return $urandom();
    endfunction

    // Read index: mostly a live element, sometimes anything the field allows.
    function automatic logic [POS_W-1:0] pick_position();
        if ((mirror.held > 0) && ($urandom_range(0, 99) < 70))
        begin
            return POS_W'($urandom_range(0, mirror.held - 1));
        end
        return POS_W'($urandom());
    endfunction

    // Directed opening: empty-store errors, null pushes, field extremes,
    // out-of-range reads, unknown ops, then drain back to empty.
    task automatic run_directed();
        send_word(OP_POP_BACK,  32'h0000_0000, 8'h00);
        send_word(OP_POP_FRONT, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_READ,      32'h0000_0000, 8'h00);
        send_word(OP_PUSH_BACK,  32'h0000_0000, 8'hFF);
        send_word(OP_PUSH_FRONT, 32'h0000_0000, 8'h00);
        send_word(OP_PUSH_BACK,  32'hFFFF_FFFF, 8'h00);
        send_word(OP_PUSH_FRONT, 32'h0000_0001, 8'hFF);
        send_word(OP_PUSH_BACK,  32'h8000_0000, 8'hAA);
        send_word(OP_PUSH_FRONT, 32'h7FFF_FFFF, 8'h55);
        send_word(OP_READ,       32'h0000_0000, 8'h00);
        send_word(OP_READ,       32'hFFFF_FFFF, 8'h03);
        send_word(OP_READ,       32'h0000_0000, 8'h04);
        send_word(OP_READ,       32'h0000_0000, 8'hFF);
        send_word(3'd5,          32'h1234_5678, 8'h01);
        send_word(3'd6,          32'hFFFF_FFFF, 8'hFF);
        send_word(3'd7,          32'h0000_0000, 8'h00);
        send_word(OP_POP_BACK,   32'h0000_0000, 8'h00);
        send_word(OP_POP_FRONT,  32'h0000_0000, 8'h00);
        send_word(OP_POP_FRONT,  32'h0000_0000, 8'h00);
        send_word(OP_POP_BACK,   32'h0000_0000, 8'h00);
        send_word(OP_POP_BACK,   32'h0000_0000, 8'h00);
        send_word(OP_READ,       32'h0000_0000, 8'h00);
    endtask

    // Random part: swing between filling and draining so that the store hits
    // both full and empty repeatedly, lingering a while at each extreme.
    task automatic run_random();
        bit               filling;
        int unsigned      roll;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] push_value;
        logic [POS_W-1:0] position;
        filling = 1'b1;
        repeat (RANDOM_WORDS)
        begin
            if (filling && (mirror.held == CAPACITY) && ($urandom_range(0, 14) == 0))
            begin
                filling = 1'b0;
            end
            else if (!filling && (mirror.held == 0) && ($urandom_range(0, 9) == 0))
            begin
                filling = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                op = filling ? OP_PUSH_BACK : OP_POP_BACK;
            end
            else if (roll < 90)
            begin
                op = filling ? OP_POP_BACK : OP_PUSH_BACK;
            end
            else if (roll < 98)
            begin
                op = OP_READ;
            end
            else
            begin
                op = OP_W'($urandom_range(5, 7));
            end
            // Pick the end at random for pushes and pops.
            if ((op == OP_PUSH_BACK || op == OP_POP_BACK) && $urandom_range(0, 1))
            begin
                op = op + 3'd1;
            end
            push_value = (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) ? pick_reference()
                                                                     : $urandom();
            position = (op == OP_READ) ? pick_position() : POS_W'($urandom());
            send_word(op, push_value, position);
        end
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    // Receiver: random stalls, a calm span, and one long hold-off that lets
    // the block fill and push back on the sender.
    initial
    begin
        int unsigned rx_cycle;
        rx_cycle     = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if ((rx_cycle >= HOLD_RX_FIRST) && (rx_cycle < HOLD_RX_LAST))
            begin
                rsp_if.ready = 1'b0;
            end
            else if ((rx_cycle >= CALM_RX_FIRST) && (rx_cycle < CALM_RX_LAST))
            begin
                rsp_if.ready = 1'b1;
            end
            else
            begin
                rsp_if.ready = ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Check every taken response against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            mirror.check_response(rsp_if.read_value, rsp_if.status, rsp_if.count);
        end
    end

    // Watchdog: abort when neither side has moved a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        words_sent        = 0;
        req_if.valid      = 1'b0;
        req_if.op         = '0;
        req_if.push_value = '0;
        req_if.position   = '0;
        repeat (9)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        run_directed();
        run_random();

        // Drain: wait for every predicted word, then let the pipe settle.
        while (mirror.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        if (mirror.failures == 0 && mirror.pending_results.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
